// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL modules; smkss_back takes them in.
// Depends on nothing; modules take it by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define ASSERT_SYNC(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

// File: hw/rtl/smkss_pkg.sv
// Package for the sampled k-mer scan: payload types, job type, constants.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package smkss_pkg;

    localparam int MAX_KMER    = 16;
    localparam int WIN_W       = 2 * MAX_KMER;
    localparam int LEN_W       = $clog2(MAX_KMER + 1);
    localparam int SH_W        = $clog2(WIN_W);
    localparam int AMT_W       = $clog2(WIN_W + 1);
    localparam int POS_W       = 32;
    localparam int DIV_W       = 32;
    localparam int STEP_W      = $clog2(WIN_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR     = 1'b1;

    localparam logic [LEN_W-1:0] KMER_LENGTH_RESET = LEN_W'(8);
    localparam logic [DIV_W-1:0] DIVISOR_RESET     = DIV_W'(1);

    typedef struct packed {
        logic [1:0]       base;
        logic             first_base;
        logic [POS_W-1:0] start_position;
        logic             last_base;
    } t_in_item;

    typedef struct packed {
        logic [WIN_W-1:0] kmer_code;
        logic [POS_W-1:0] kmer_position;
        logic             forward_strand;
        logic             last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [WIN_W-1:0] kmer_fwd;
        logic [WIN_W-1:0] kmer_rc;
        logic [POS_W-1:0] kmer_position;
    } t_job;

endpackage

// File: hw/rtl/smkss_front.sv
// Front end: takes bases, keeps both strand windows and forms k-mer jobs.
// Depends on smkss_pkg.
`timescale 1ns / 1ps

module smkss_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  smkss_pkg::t_in_item            i_in_data,
    input  logic [smkss_pkg::LEN_W-1:0]    i_kmer_length,
    input  logic                           i_q_ready,
    output logic                           o_push,
    output smkss_pkg::t_job                o_job
);

    logic [smkss_pkg::WIN_W-1:0] r_fwd_win, r_rc_win;
    logic [smkss_pkg::LEN_W-1:0] r_fill;
    logic [smkss_pkg::POS_W-1:0] r_pos;

    logic [smkss_pkg::WIN_W-1:0] eff_fwd, eff_rc, n_fwd_win, n_rc_win;
    logic [smkss_pkg::LEN_W-1:0] eff_fill, n_fill;
    logic [smkss_pkg::POS_W-1:0] cur_pos;
    logic [smkss_pkg::SH_W-1:0]  fwd_shift;
    logic [smkss_pkg::AMT_W-1:0] mask_amt;
    logic [smkss_pkg::WIN_W:0]   wide_mask;
    logic                        accept;

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && i_q_ready;

    // A first base starts from empty windows.
    assign eff_fwd  = i_in_data.first_base ? '0 : r_fwd_win;
    assign eff_rc   = i_in_data.first_base ? '0 : r_rc_win;
    assign eff_fill = i_in_data.first_base ? '0 : r_fill;
    assign cur_pos  = i_in_data.first_base ? i_in_data.start_position : r_pos;

    assign n_fwd_win = {i_in_data.base, eff_fwd[smkss_pkg::WIN_W-1:2]};
    assign n_rc_win  = {eff_rc[smkss_pkg::WIN_W-3:0], ~i_in_data.base};
    assign n_fill    = (eff_fill == smkss_pkg::LEN_W'(smkss_pkg::MAX_KMER)) ?
                       eff_fill : eff_fill + smkss_pkg::LEN_W'(1);

    assign fwd_shift = smkss_pkg::SH_W'(2 * (smkss_pkg::MAX_KMER - int'(i_kmer_length)));
    assign mask_amt  = smkss_pkg::AMT_W'(2 * int'(i_kmer_length));
    assign wide_mask = ~({(smkss_pkg::WIN_W + 1){1'b1}} << mask_amt);

    assign o_job.kmer_fwd      = n_fwd_win >> fwd_shift;
    assign o_job.kmer_rc       = n_rc_win & wide_mask[smkss_pkg::WIN_W-1:0];
    assign o_job.kmer_position = cur_pos - smkss_pkg::POS_W'(i_kmer_length)
                                 + smkss_pkg::POS_W'(1);
    assign o_push = accept && (n_fill >= i_kmer_length);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_win <= '0;
            r_rc_win  <= '0;
            r_fill    <= '0;
            r_pos     <= '0;
        end else if (accept) begin
            r_pos <= cur_pos + smkss_pkg::POS_W'(1);
            if (i_in_data.last_base) begin
                r_fwd_win <= '0;
                r_rc_win  <= '0;
                r_fill    <= '0;
            end else begin
                r_fwd_win <= n_fwd_win;
                r_rc_win  <= n_rc_win;
                r_fill    <= n_fill;
            end
        end
    end

endmodule

// File: hw/rtl/smkss_queue.sv
// Short job queue between the front end and the modulo back end.
// Depends on smkss_pkg.
`timescale 1ns / 1ps

module smkss_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  smkss_pkg::t_job i_job,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_pop,
    output smkss_pkg::t_job o_job
);

    smkss_pkg::t_job r_mem [smkss_pkg::QUEUE_DEPTH];
    logic [smkss_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [smkss_pkg::QCNT_W-1:0] r_count;
    logic do_push, do_pop;

    localparam logic [smkss_pkg::QPTR_W-1:0] PTR_LAST =
        smkss_pkg::QPTR_W'(smkss_pkg::QUEUE_DEPTH - 1);

    assign o_ready = (r_count != smkss_pkg::QCNT_W'(smkss_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/smkss_back.sv
// Back end: bit-serial remainder unit testing both codes, and the result register.
// Depends on smkss_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smkss_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [smkss_pkg::DIV_W-1:0]    i_divisor,
    input  logic                           i_q_valid,
    input  smkss_pkg::t_job                i_job,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output smkss_pkg::t_out_item           o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FWD,
        S_RC,
        S_EMIT_F,
        S_EMIT_R
    } t_state;

    localparam logic [smkss_pkg::STEP_W-1:0] STEP_LAST =
        smkss_pkg::STEP_W'(smkss_pkg::WIN_W - 1);

    t_state                        r_state;
    smkss_pkg::t_job               r_job;
    logic [smkss_pkg::WIN_W-1:0]   r_dvd;
    logic [smkss_pkg::DIV_W-1:0]   r_rem;
    logic [smkss_pkg::STEP_W-1:0]  r_cnt;
    logic                          r_fwd_pass, r_rc_pass;
    logic                          r_out_valid;
    smkss_pkg::t_out_item          r_out;

    logic [smkss_pkg::DIV_W:0]     trial, diff;
    logic [smkss_pkg::DIV_W-1:0]   n_rem;
    logic                          n_pass, out_free, load_out;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    assign trial  = {r_rem, r_dvd[smkss_pkg::WIN_W-1]};
    assign diff   = trial - {1'b0, i_divisor};
    assign n_rem  = (trial >= {1'b0, i_divisor}) ? diff[smkss_pkg::DIV_W-1:0]
                                                 : trial[smkss_pkg::DIV_W-1:0];
    assign n_pass = (i_divisor != '0) && (n_rem == '0);

    assign out_free    = !r_out_valid || i_out_ready;
    // A passing code moves into the result register this cycle.
    assign load_out    = out_free &&
                         ((r_state == S_EMIT_F && r_fwd_pass) ||
                          (r_state == S_EMIT_R && r_rc_pass));
    assign o_pop       = (r_state == S_IDLE) && i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_fwd_pass  <= 1'b0;
            r_rc_pass   <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_job   <= i_job;
                        r_dvd   <= i_job.kmer_fwd;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_FWD;
                    end
                end
                S_FWD: begin
                    if (r_cnt == STEP_LAST) begin
                        r_fwd_pass <= n_pass;
                        r_dvd      <= r_job.kmer_rc;
                        r_rem      <= '0;
                        r_cnt      <= '0;
                        r_state    <= S_RC;
                    end else begin
                        r_rem <= n_rem;
                        r_dvd <= r_dvd << 1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_RC: begin
                    if (r_cnt == STEP_LAST) begin
                        r_rc_pass <= n_pass;
                        r_cnt     <= '0;
                        r_state   <= S_EMIT_F;
                    end else begin
                        r_rem <= n_rem;
                        r_dvd <= r_dvd << 1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_EMIT_F: begin
                    if (!r_fwd_pass) begin
                        r_state <= S_EMIT_R;
                    end else if (out_free) begin
                        r_out.kmer_code      <= r_job.kmer_fwd;
                        r_out.kmer_position  <= r_job.kmer_position;
                        r_out.forward_strand <= 1'b1;
                        r_out.last_of_run    <= !r_rc_pass;
                        r_state              <= S_EMIT_R;
                    end
                end
                S_EMIT_R: begin
                    if (!r_rc_pass) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out.kmer_code      <= r_job.kmer_rc;
                        r_out.kmer_position  <= r_job.kmer_position;
                        r_out.forward_strand <= 1'b0;
                        r_out.last_of_run    <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_SYNC(a_rc_result_is_last, i_clk, i_rst_n,
        (r_out_valid && !r_out.forward_strand) |-> r_out.last_of_run)
    `ASSERT_SYNC(a_fwd_done_starts_rc, i_clk, i_rst_n,
        (r_state == S_FWD && r_cnt == STEP_LAST) |=> (r_state == S_RC && r_cnt == '0))
    `ASSERT_SYNC(a_result_from_emit, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(r_state == S_EMIT_F || r_state == S_EMIT_R))

endmodule

// File: hw/rtl/mod_sampled_kmer_scan_both_strands_top.sv
// Top level of the modulo-sampled k-mer scan over both strands.
// Depends on smkss_pkg, smkss_front, smkss_queue and smkss_back.
`timescale 1ns / 1ps

// The block takes one 2-bit base per input transaction and keeps a sliding
// window of the last bases on both strands. Once kmer_length bases of the
// current sequence are held, each base forms a forward k-mer code (first base
// in the low bits) and its reverse complement, both starting at the same
// position. Each code divisible by the divisor becomes an output transaction,
// forward first, with last_of_run set on the final one for that base; a zero
// divisor passes nothing. Every base is taken in a single cycle while the job
// queue has room; when the queue is full the input waits. A base that
// completes a k-mer holds the back end through a load state, 32 remainder
// steps for each code in the bit-serial remainder unit and two emit states;
// it takes no new job before it returns to idle. A two-entry job queue lets
// the front end take bases while the remainder unit is busy, and the output
// register lets the next job start while a result waits to be taken.
// Configuration writes take effect at once and are meant to be made only
// while the block is idle; a kmer_length of zero is stored as one and a value
// above sixteen as sixteen. Only the low five bits of a written length count.

module mod_sampled_kmer_scan_both_strands_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  smkss_pkg::t_in_item                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output smkss_pkg::t_out_item                o_out_data,
    input  logic                                i_cfg_we,
    input  logic [smkss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [smkss_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // Configuration registers.
    logic [smkss_pkg::LEN_W-1:0] r_kmer_length;
    logic [smkss_pkg::DIV_W-1:0] r_divisor;
    logic [smkss_pkg::LEN_W-1:0] n_kmer_length;
    logic [smkss_pkg::LEN_W-1:0] wr_len;

    // Front end to queue, queue to back end.
    logic            push, q_ready, q_valid, pop;
    smkss_pkg::t_job front_job, q_job;

    // Written lengths are clamped into the supported range.
    assign wr_len = i_cfg_data[smkss_pkg::LEN_W-1:0];
    always_comb begin
        if (wr_len == '0) begin
            n_kmer_length = smkss_pkg::LEN_W'(1);
        end else if (wr_len > smkss_pkg::LEN_W'(smkss_pkg::MAX_KMER)) begin
            n_kmer_length = smkss_pkg::LEN_W'(smkss_pkg::MAX_KMER);
        end else begin
            n_kmer_length = wr_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length <= smkss_pkg::KMER_LENGTH_RESET;
            r_divisor     <= smkss_pkg::DIVISOR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                smkss_pkg::CFG_KMER_LENGTH: r_kmer_length <= n_kmer_length;
                smkss_pkg::CFG_DIVISOR:     r_divisor     <= i_cfg_data[smkss_pkg::DIV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front end shifts bases into the windows and queues one job for
    // every base that completes a k-mer.
    smkss_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .i_kmer_length (r_kmer_length),
        .i_q_ready     (q_ready),
        .o_push        (push),
        .o_job         (front_job)
    );

    smkss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (q_job)
    );

    // The back end tests both codes and hands passing codes to the output.
    smkss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_divisor   (r_divisor),
        .i_q_valid   (q_valid),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: tb/mod_sampled_kmer_scan_both_strands_top_test.sv
// Self-checking testbench for the modulo-sampled k-mer scan over both strands.
// It streams DNA bases into the block and checks every emitted k-mer result
// against a predictor built into this file. It depends on smkss_pkg.
`timescale 1ns / 1ps

module mod_sampled_kmer_scan_both_strands_top_test;

    // Number of random bases wanted after the directed part.
    localparam int RANDOM_BASES = 1000;
    // Cycles to let pass after the last result before a configuration write or
    // the end. The block keeps up to three k-mer jobs in flight, and each one
    // holds the back end through all of its remainder steps even when nothing passes.
    localparam int SETTLE_CYCLES = 400;
    // Length of the one long receiver hold that fills the block and stalls it.
    localparam int LONG_HOLD_CYCLES = 1500;
    // Mismatches beyond this count are only counted, not printed.
    localparam int MAX_REPORTS = 10;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                o_in_ready;
    smkss_pkg::t_in_item                 in_data = '0;
    logic                                o_out_valid;
    logic                                out_ready = 1'b0;
    smkss_pkg::t_out_item                o_out_data;
    logic                                cfg_we = 1'b0;
    logic [smkss_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [smkss_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

    mod_sampled_kmer_scan_both_strands_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // The clock has a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Bases waiting to be offered, and k-mer results waiting to be seen.
    smkss_pkg::t_in_item   pending_bases[$];
    smkss_pkg::t_out_item  awaited_kmers[$];

    // The predictor's copy of the registers and of the scan state.
    int                          kmer_len = 8;
    logic [31:0]                 divisor = 32'd1;
    logic [smkss_pkg::WIN_W-1:0] fwd_win = '0;
    logic [smkss_pkg::WIN_W-1:0] rc_win = '0;
    int                          fill_cnt = 0;
    logic [31:0]                 next_pos = '0;

    // Shared knobs. When no_idle is set neither side inserts gaps, which gives
    // stretches of full-rate traffic. hold_wanted asks for the one long hold.
    logic no_idle = 1'b0;
    logic hold_wanted = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    int send_gap = 0;
    int recv_wait = 0;
    int queued_bases = 0;
    int bases_taken = 0;
    int fwd_results = 0;
    int rc_results = 0;
    int mismatches = 0;
    int configs_used = 0;

    // Works out the results that one accepted base causes. The forward window
    // shifts the new base in at the top, so the k-mer's first base ends up in
    // the low bits once the window is shifted down; the reverse-complement
    // window shifts the complement in at the bottom.
    task automatic predict_kmers(input smkss_pkg::t_in_item item);
        logic [31:0]          pos;
        logic [31:0]          mask;
        logic [31:0]          fcode;
        logic [31:0]          rcode;
        logic                 pass_f;
        logic                 pass_r;
        smkss_pkg::t_out_item hit;
        if (item.first_base) begin
            fwd_win = '0;
            rc_win = '0;
            fill_cnt = 0;
            pos = item.start_position;
        end else begin
            pos = next_pos;
        end
        fwd_win = {item.base, fwd_win[smkss_pkg::WIN_W-1:2]};
        rc_win = {rc_win[smkss_pkg::WIN_W-3:0], 2'd3 - item.base};
        if (fill_cnt < smkss_pkg::MAX_KMER)
            fill_cnt++;
        if (fill_cnt >= kmer_len) begin
            mask = (kmer_len == smkss_pkg::MAX_KMER) ? '1
                                                     : (32'd1 << (2 * kmer_len)) - 32'd1;
            fcode = (fwd_win >> (2 * (smkss_pkg::MAX_KMER - kmer_len))) & mask;
            rcode = rc_win & mask;
            // A zero divisor lets nothing through.
            pass_f = (divisor != 0) && ((fcode % divisor) == 0);
            pass_r = (divisor != 0) && ((rcode % divisor) == 0);
            hit.kmer_position = pos - 32'(kmer_len - 1);
            if (pass_f) begin
                hit.kmer_code = fcode;
                hit.forward_strand = 1'b1;
                hit.last_of_run = !pass_r;
                awaited_kmers.push_back(hit);
            end
            if (pass_r) begin
                hit.kmer_code = rcode;
                hit.forward_strand = 1'b0;
                hit.last_of_run = 1'b1;
                awaited_kmers.push_back(hit);
            end
        end
        next_pos = pos + 32'd1;
        if (item.last_base) begin
            fwd_win = '0;
            rc_win = '0;
            fill_cnt = 0;
        end
    endtask

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Input driver. A transaction completes when valid and ready are both high
    // at an edge; the predictor runs right then, so it always sees bases in
    // the order the block took them. After each transaction the driver waits
    // the gap drawn for it before it offers the next base.
    always @(posedge i_clk) begin : base_driver
        logic offering;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            offering = in_valid;
            if (in_valid && o_in_ready) begin
                predict_kmers(in_data);
                bases_taken++;
                offering = 1'b0;
            end
            if (!offering) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_bases.size() != 0) begin
                    in_data <= pending_bases.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= no_idle ? 0 : $urandom_range(0, 17);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor. Each result transaction is checked field by field
    // against the oldest awaited result. After each one the receiver drops
    // ready for a drawn number of cycles, and also for as long as the long
    // hold runs.
    always @(posedge i_clk) begin : kmer_monitor
        int                   wait_cycles;
        smkss_pkg::t_out_item want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end else begin
            wait_cycles = recv_wait;
            if (o_out_valid && out_ready) begin
                if (o_out_data.forward_strand)
                    fwd_results++;
                else
                    rc_results++;
                if (awaited_kmers.size() == 0) begin
                    note_failure($sformatf("unexpected result code %h pos %h fwd %b last %b",
                        o_out_data.kmer_code, o_out_data.kmer_position,
                        o_out_data.forward_strand, o_out_data.last_of_run));
                end else begin
                    want = awaited_kmers.pop_front();
                    if (o_out_data.kmer_code !== want.kmer_code ||
                        o_out_data.kmer_position !== want.kmer_position ||
                        o_out_data.forward_strand !== want.forward_strand ||
                        o_out_data.last_of_run !== want.last_of_run)
                        note_failure($sformatf(
                            "expected code %h pos %h fwd %b last %b, got %h %h %b %b",
                            want.kmer_code, want.kmer_position, want.forward_strand,
                            want.last_of_run, o_out_data.kmer_code,
                            o_out_data.kmer_position, o_out_data.forward_strand,
                            o_out_data.last_of_run));
                end
                wait_cycles = no_idle ? 0 : $urandom_range(0, 17);
            end else if (wait_cycles != 0) begin
                wait_cycles--;
            end
            recv_wait <= wait_cycles;
            out_ready <= (wait_cycles == 0) && (hold_left == 0);
        end
    end

    // The long receiver hold counts its own cycles. While it runs the sender
    // keeps offering bases, so the job queue and output register fill up and
    // the block has to stall its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_wanted && !hold_done) begin
            hold_left <= LONG_HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic push_base(input logic [1:0] b, input logic first,
                             input logic [31:0] start, input logic last);
        smkss_pkg::t_in_item item;
        item.base = b;
        item.first_base = first;
        item.start_position = start;
        item.last_base = last;
        pending_bases.push_back(item);
        queued_bases++;
    endtask

    // Writes both registers back to back; the block must be idle. The
    // predictor stores the length the way the block does: zero becomes one
    // and anything above the maximum becomes the maximum.
    task automatic set_config(input logic [4:0] len_raw, input logic [31:0] div_val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= smkss_pkg::CFG_KMER_LENGTH;
        cfg_data <= 32'(len_raw);
        @(posedge i_clk);
        cfg_index <= smkss_pkg::CFG_DIVISOR;
        cfg_data <= div_val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (len_raw == 0)
            kmer_len = 1;
        else if (len_raw > smkss_pkg::MAX_KMER)
            kmer_len = smkss_pkg::MAX_KMER;
        else
            kmer_len = len_raw;
        divisor = div_val;
        configs_used++;
        @(negedge i_clk);
    endtask

    // Waits until every queued base is taken and every awaited result seen,
    // then lets the block finish any base that produces nothing.
    task automatic drain;
        while (pending_bases.size() != 0 || in_valid || awaited_kmers.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Random sequences are sometimes biased to one base, which makes codes
    // of all zeros or all ones, the ones that large divisors let through.
    function automatic logic [1:0] pick_base(input int flavor);
        if (flavor == 1 && $urandom_range(0, 7) != 0)
            return 2'd0;
        if (flavor == 2 && $urandom_range(0, 7) != 0)
            return 2'd3;
        return 2'($urandom_range(0, 3));
    endfunction

    // Start positions cluster near both ends of the range so that positions
    // wrap within sequences.
    function automatic logic [31:0] pick_start;
        case ($urandom_range(0, 3))
            0: return 32'hFFFF_FFFF - $urandom_range(0, 40);
            1: return 32'($urandom_range(0, 40));
            default: return $urandom();
        endcase
    endfunction

    initial begin : stimulus
        int          seq_len;
        int          flavor;
        int          restart_at;
        int          n_left;
        logic        open_start;
        logic        no_last;
        logic        is_first;
        logic        continue_seq;
        logic [4:0]  len_raw;
        logic [31:0] div_val;
        logic [31:0] st;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset values (length 8, divisor 1): a sequence whose positions wrap
        // past the top of the range, then a lone base that is both first and
        // last, which is too short to emit anything.
        push_base(2'd0, 1'b1, 32'hFFFF_FFFE, 1'b0);
        push_base(2'd1, 1'b0, 32'hDEAD_BEEF, 1'b0);
        push_base(2'd2, 1'b0, 32'h0, 1'b0);
        push_base(2'd3, 1'b0, 32'h0, 1'b0);
        push_base(2'd3, 1'b0, 32'h0, 1'b0);
        push_base(2'd2, 1'b0, 32'h0, 1'b0);
        push_base(2'd1, 1'b0, 32'h0, 1'b0);
        push_base(2'd0, 1'b0, 32'h0, 1'b0);
        push_base(2'd1, 1'b0, 32'h0, 1'b1);
        push_base(2'd2, 1'b1, 32'h8000_0000, 1'b1);
        drain();

        // Length above the maximum, largest divisor: sixteen threes give a
        // forward code of all ones and a reverse complement of zero, and both
        // divide evenly.
        set_config(5'd31, 32'hFFFF_FFFF);
        for (int i = 0; i < smkss_pkg::MAX_KMER; i++)
            push_base(2'd3, i == 0, 32'h1234_5678, i == smkss_pkg::MAX_KMER - 1);
        drain();

        // Length zero is stored as one; a zero divisor passes nothing.
        set_config(5'd0, 32'd0);
        push_base(2'd0, 1'b1, 32'h0, 1'b0);
        push_base(2'd3, 1'b0, 32'hFFFF_FFFF, 1'b1);
        drain();

        // Full pressure: every k-mer passes and gives two results, the sender
        // never idles and the receiver holds off for a long stretch.
        set_config(5'd4, 32'd1);
        no_idle = 1'b1;
        hold_wanted = 1'b1;
        for (int i = 0; i < 60; i++)
            push_base(pick_base(0), i == 0, pick_start(), i == 59);
        drain();

        // Random phases. Each picks a configuration, then queues mostly
        // well-formed sequences with random content, mixed with lone noise
        // bases, sequences that never end, and restarts in mid-sequence. The
        // first sequence of a phase sometimes carries on the window left over
        // from the last phase under the new length.
        while (queued_bases < RANDOM_BASES + 88) begin
            case ($urandom_range(0, 7))
                0: len_raw = 5'd0;
                1: len_raw = 5'($urandom_range(17, 31));
                2: len_raw = 5'd16;
                3: len_raw = 5'd1;
                default: len_raw = 5'($urandom_range(2, 15));
            endcase
            case ($urandom_range(0, 9))
                0: div_val = 32'd0;
                1: div_val = 32'hFFFF_FFFF;
                2, 3, 4, 5: div_val = 32'($urandom_range(1, 7));
                6: div_val = 32'd1;
                7: div_val = 32'd1 << $urandom_range(0, 31);
                8: div_val = 32'($urandom_range(1, 1000));
                default: div_val = $urandom();
            endcase
            set_config(len_raw, div_val);
            no_idle = ($urandom_range(0, 3) == 0);
            n_left = $urandom_range(30, 90);
            continue_seq = ($urandom_range(0, 3) == 0);
            while (n_left > 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_base(pick_base(0), 1'($urandom_range(0, 1)), $urandom(),
                              1'($urandom_range(0, 1)));
                    n_left--;
                end else begin
                    if ($urandom_range(0, 4) == 0)
                        seq_len = $urandom_range(1, kmer_len);
                    else
                        seq_len = kmer_len + $urandom_range(0, 30);
                    flavor = $urandom_range(0, 3);
                    open_start = continue_seq;
                    no_last = ($urandom_range(0, 5) == 0);
                    restart_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, seq_len) : 0;
                    st = pick_start();
                    for (int i = 0; i < seq_len; i++) begin
                        is_first = (i == 0) ? !open_start : (i == restart_at);
                        push_base(pick_base(flavor), is_first,
                                  (i == 0) ? st : $urandom(),
                                  (i == seq_len - 1) && !no_last);
                    end
                    n_left -= seq_len;
                end
                continue_seq = 1'b0;
            end
            drain();
        end

        $display("Scanned %0d bases under %0d register settings, including a long output hold.",
                 bases_taken, configs_used);
        $display("Checked %0d forward and %0d reverse-complement results; %0d mismatches.",
                 fwd_results, rc_results, mismatches);
        if (mismatches == 0 && awaited_kmers.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: ends a run that has not finished in time with a failure.
    initial begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
